>>> src/brtb64_pkg.sv
// Package with widths and exponent re-bias constants for the token to binary64 converter.
`default_nettype none

package brtb64_pkg;

	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned COUNT_W   = 3;
	localparam int unsigned RESULT_W  = 64;

	localparam int unsigned EXP_W  = 11;
	localparam int unsigned MANT_W = 52;
	localparam int unsigned SP_EXP_W = 8;

	// Byte counts minus one, as carried on extra_bytes.
	localparam logic [COUNT_W-1:0] SIZE_1 = 3'd0;
	localparam logic [COUNT_W-1:0] SIZE_2 = 3'd1;
	localparam logic [COUNT_W-1:0] SIZE_3 = 3'd2;
	localparam logic [COUNT_W-1:0] SIZE_4 = 3'd3;
	localparam logic [COUNT_W-1:0] SIZE_5 = 3'd4;
	localparam logic [COUNT_W-1:0] SIZE_6 = 3'd5;
	localparam logic [COUNT_W-1:0] SIZE_7 = 3'd6;
	localparam logic [COUNT_W-1:0] SIZE_8 = 3'd7;

	// Re-bias into the single-precision exponent: 128 - 2^(r-1), modulo 256.
	localparam logic [SP_EXP_W-1:0] SP_BIAS_1 = 8'd124;
	localparam logic [SP_EXP_W-1:0] SP_BIAS_2 = 8'd112;
	localparam logic [SP_EXP_W-1:0] SP_BIAS_3 = 8'd64;

	// Single to double exponent widening.
	localparam logic [EXP_W-1:0] SP_TO_DP_BIAS = 11'd896;

	// Re-bias straight into the double exponent: 1024 - 2^(r-1), modulo 2048.
	localparam logic [EXP_W-1:0] DP_BIAS_5 = 11'd768;
	localparam logic [EXP_W-1:0] DP_BIAS_6 = 11'd512;

endpackage

`default_nettype wire

>>> src/binary_rational_token_to_binary64.sv
// Top level of the compact floating token to binary64 converter.
`default_nettype none

// Converts the payload of a compact binary floating token (one to eight
// little-endian bytes, extra_bytes giving the count minus one) into the
// same number as a binary64 bit pattern. The block never stalls: busy is
// always low, so a transaction is taken on every cycle that start is high.
// Each accepted transaction yields exactly one result:
// the inputs are captured in a first register, decoded by a short
// combinational path of byte alignment and at most two short exponent
// adds (an 8-bit re-bias for the three shortest sizes, then one 11-bit
// add), and the result is held in an output register for one cycle with
// done high.
// The receiver cannot hold results off, so no result is ever buffered
// beyond that single cycle, and a new transaction can enter every cycle.
// No exponent code is treated specially: all values are re-biased alike,
// and payload bytes above the selected count are ignored.

module binary_rational_token_to_binary64 (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [brtb64_pkg::PAYLOAD_W-1:0]  payload,
	input  wire logic [brtb64_pkg::COUNT_W-1:0]    extra_bytes,
	output logic                                   done,
	output logic      [brtb64_pkg::RESULT_W-1:0]   binary64_bits
);
	import brtb64_pkg::*;

	logic                 valid_s1;
	logic [PAYLOAD_W-1:0] payload_s1;
	logic [COUNT_W-1:0]   count_s1;
	logic [RESULT_W-1:0]  decoded;
	logic                 valid_s2;
	logic [RESULT_W-1:0]  result_s2;

	// Nothing in the path ever waits, so the block is always ready.
	assign busy = 1'b0;

	// Control bits of both stages are reset; payload registers are not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the incoming transaction.
	always_ff @(posedge clk) begin
		if (start) begin
			payload_s1 <= payload;
			count_s1   <= extra_bytes;
		end
	end

	brtb64_decode u_decode (
		.payload       (payload_s1),
		.extra_bytes   (count_s1),
		.binary64_bits (decoded)
	);

	// The result register drives the output ports; it is loaded once per transaction.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign done          = valid_s2;
	assign binary64_bits = result_s2;

endmodule

`default_nettype wire

>>> src/brtb64_decode.sv
// Combinational decode of one token payload into a binary64 bit pattern.
`default_nettype none

module brtb64_decode (
	input  wire logic [brtb64_pkg::PAYLOAD_W-1:0] payload,
	input  wire logic [brtb64_pkg::COUNT_W-1:0]   extra_bytes,
	output logic      [brtb64_pkg::RESULT_W-1:0]  binary64_bits
);
	import brtb64_pkg::*;

	logic                sign;
	logic [SP_EXP_W-1:0] sp_exp;
	logic [EXP_W-1:0]    exp;
	logic [MANT_W-1:0]   mant;

	always_comb begin
		sp_exp = '0;
		case (extra_bytes)
			SIZE_1: begin
				sign   = payload[7];
				sp_exp = SP_EXP_W'(payload[6:4]) + SP_BIAS_1;
				exp    = EXP_W'(sp_exp) + SP_TO_DP_BIAS;
				mant   = {payload[3:0], 48'd0};
			end
			SIZE_2: begin
				sign   = payload[15];
				sp_exp = SP_EXP_W'(payload[14:10]) + SP_BIAS_2;
				exp    = EXP_W'(sp_exp) + SP_TO_DP_BIAS;
				mant   = {payload[9:0], 42'd0};
			end
			SIZE_3: begin
				sign   = payload[23];
				sp_exp = SP_EXP_W'(payload[22:16]) + SP_BIAS_3;
				exp    = EXP_W'(sp_exp) + SP_TO_DP_BIAS;
				mant   = {payload[15:0], 36'd0};
			end
			SIZE_4: begin
				sign = payload[31];
				exp  = EXP_W'(payload[30:23]) + SP_TO_DP_BIAS;
				mant = {payload[22:0], 29'd0};
			end
			SIZE_5: begin
				sign = payload[39];
				exp  = EXP_W'(payload[38:30]) + DP_BIAS_5;
				mant = {payload[29:0], 22'd0};
			end
			SIZE_6: begin
				sign = payload[47];
				exp  = EXP_W'(payload[46:37]) + DP_BIAS_6;
				mant = {payload[36:0], 15'd0};
			end
			SIZE_7: begin
				sign = payload[55];
				exp  = payload[54:44];
				mant = {payload[43:0], 8'd0};
			end
			default: begin
				sign = payload[63];
				exp  = payload[62:52];
				mant = payload[51:0];
			end
		endcase
		binary64_bits = {sign, exp, mant};
	end

endmodule

`default_nettype wire
